/* rtl/twdl_pkg.sv */
// shared types and constants for the two-wire debug link
package twdl_pkg;

  localparam logic [3:0]  BITS_PER_CHAR = 4'd8;
  localparam logic [7:0]  TURN_BYTE     = 8'h80;
  localparam logic [3:0]  READY_STROBE  = 4'h4;
  localparam logic [3:0]  PORT_IDLE     = 4'h0;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  typedef struct packed {
    logic       clock_line;
    logic       data_line;
    logic       host_char_valid;
    logic [7:0] host_char;
  } poll_t;

  typedef struct packed {
    logic       is_port_write;
    logic [3:0] port_value;
    logic       is_rx_byte;
    logic [6:0] rx_byte;
    logic       last;
  } result_t;

  typedef enum logic [2:0] {
    PH_WAIT_START = 3'd0,
    PH_START      = 3'd1,
    PH_LOW        = 3'd2,
    PH_HI_FIRST   = 3'd3,
    PH_HI_NEXT    = 3'd4,
    PH_WAIT_SEND  = 3'd5,
    PH_SEND       = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_STROBE = 2'd1,
    ACT_RX     = 2'd2,
    ACT_SEND   = 2'd3
  } act_t;

  typedef struct packed {
    logic       tmo;
    act_t       act;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_LEAD = 2'd0,
    BK_BITS = 2'd1,
    BK_PAD0 = 2'd2,
    BK_PAD1 = 2'd3
  } back_state_t;

endpackage

/* rtl/twdl_front.sv */
// poll decoder: line sampling, byte assembly, host timeout, command issue
module twdl_front import twdl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        accept,
  input  poll_t       poll,
  output logic        push,
  output cmd_t        cmd
);

  logic [15:0] timeout_polls;
  phase_t      phase, phase_next;
  logic        prev_clk, prev_dat;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  assembled, assembled_next;
  logic [7:0]  pending, pending_next;
  logic        armed, armed_next;
  logic [15:0] ticks, ticks_next;

  always_comb begin
    phase_next     = phase;
    bit_count_next = bit_count;
    assembled_next = assembled;
    pending_next   = pending;
    armed_next     = armed;
    ticks_next     = ticks;
    cmd            = '{tmo: 1'b0, act: ACT_NONE, data: 8'h00};

    if (armed) begin
      if (ticks >= timeout_polls) begin
        cmd.tmo    = 1'b1;
        phase_next = PH_WAIT_START;
        ticks_next = '0;
        armed_next = 1'b0;
      end else begin
        ticks_next = ticks + 16'd1;
      end
    end

    if (poll.host_char_valid) begin
      pending_next = poll.host_char;
      phase_next   = PH_WAIT_SEND;
      ticks_next   = '0;
      armed_next   = 1'b1;
    end

    unique case (phase_next)
      PH_WAIT_START: begin
        if (prev_clk && prev_dat && poll.clock_line && !poll.data_line) begin
          if (bit_count != 4'd0 && bit_count < BITS_PER_CHAR) begin
            armed_next     = 1'b0;
            ticks_next     = '0;
            bit_count_next = BITS_PER_CHAR;
          end else begin
            phase_next = PH_START;
          end
        end
      end
      PH_START: begin
        bit_count_next = '0;
        assembled_next = '0;
        if (!poll.clock_line) phase_next = PH_LOW;
      end
      PH_LOW: begin
        phase_next = PH_HI_FIRST;
      end
      PH_HI_FIRST: begin
        if (poll.clock_line) begin
          if (bit_count < 4'd8) begin
            assembled_next[bit_count[2:0]] = assembled[bit_count[2:0]] | poll.data_line;
          end
          bit_count_next = bit_count + 4'd1;
          if (bit_count_next == BITS_PER_CHAR && assembled_next == TURN_BYTE) begin
            cmd.act    = ACT_STROBE;
            phase_next = PH_SEND;
          end else begin
            if (bit_count_next == BITS_PER_CHAR) begin
              if (assembled_next < TURN_BYTE) begin
                cmd.act  = ACT_RX;
                cmd.data = assembled_next;
              end
              assembled_next = '0;
            end
            phase_next = PH_HI_NEXT;
          end
        end
      end
      PH_HI_NEXT: begin
        if (!poll.clock_line) begin
          phase_next = (bit_count == BITS_PER_CHAR) ? PH_WAIT_START : PH_LOW;
        end
      end
      PH_WAIT_SEND: begin
        cmd.act    = ACT_STROBE;
        phase_next = PH_WAIT_START;
      end
      PH_SEND: begin
        armed_next = 1'b0;
        ticks_next = '0;
        cmd.act    = ACT_SEND;
        cmd.data   = pending;
        phase_next = PH_WAIT_START;
      end
      default: begin
      end
    endcase
  end

  assign push = accept && (cmd.tmo || cmd.act != ACT_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_polls <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_polls <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_WAIT_START;
      prev_clk  <= 1'b0;
      prev_dat  <= 1'b0;
      bit_count <= BITS_PER_CHAR;
      assembled <= '0;
      pending   <= '0;
      armed     <= 1'b0;
      ticks     <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      prev_clk  <= poll.clock_line;
      prev_dat  <= poll.data_line;
      bit_count <= bit_count_next;
      assembled <= assembled_next;
      pending   <= pending_next;
      armed     <= armed_next;
      ticks     <= ticks_next;
    end
  end

endmodule

/* rtl/twdl_queue.sv */
// command queue between the poll decoder and the result sequencer
module twdl_queue import twdl_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));
  assign head  = slots[rd_ptr];

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    wrap_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wrap_inc(wr_ptr);
      if (pop)  rd_ptr <= wrap_inc(rd_ptr);
      if (push && !pop)      count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

endmodule

/* rtl/twdl_back.sv */
// result sequencer: expands queued commands into result transactions
module twdl_back import twdl_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cmd_t    head,
  input  logic    empty,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  back_state_t state, state_next;
  logic [2:0]  bit_idx, bit_idx_next;
  logic [1:0]  sub, sub_next;
  logic        tmo_done, tmo_done_next;
  logic        load, bit_step, cur_bit;
  result_t     res;

  assign load    = !empty && (!out_valid || out_ready);
  assign cur_bit = head.data[bit_idx];

  always_comb begin
    state_next    = state;
    bit_idx_next  = bit_idx;
    sub_next      = sub;
    tmo_done_next = tmo_done;
    bit_step      = 1'b0;
    res           = '0;

    unique case (state)
      BK_LEAD: begin
        if (head.tmo && !tmo_done) begin
          res.is_port_write = 1'b1;
          res.port_value    = PORT_IDLE;
          res.last          = (head.act == ACT_NONE);
          if (load) tmo_done_next = !res.last;
        end else begin
          case (head.act)
            ACT_STROBE: begin
              res.is_port_write = 1'b1;
              res.port_value    = READY_STROBE;
              res.last          = 1'b1;
            end
            ACT_RX: begin
              res.is_rx_byte = 1'b1;
              res.rx_byte    = head.data[6:0];
              res.last       = 1'b1;
            end
            ACT_SEND: bit_step = 1'b1;
            default: begin
            end
          endcase
          if (load && res.last) tmo_done_next = 1'b0;
        end
      end
      BK_BITS: bit_step = 1'b1;
      BK_PAD0: begin
        res.is_port_write = 1'b1;
        res.port_value    = PORT_IDLE;
        if (load) state_next = BK_PAD1;
      end
      BK_PAD1: begin
        res.is_port_write = 1'b1;
        res.port_value    = PORT_IDLE;
        res.last          = 1'b1;
        if (load) begin
          state_next    = BK_LEAD;
          tmo_done_next = 1'b0;
        end
      end
      default: state_next = BK_LEAD;
    endcase

    if (bit_step) begin
      res.is_port_write = 1'b1;
      res.port_value    = {cur_bit, (sub == 2'd1), 2'b00};
      if (load) begin
        if (sub == 2'd2) begin
          sub_next     = '0;
          bit_idx_next = bit_idx + 3'd1;
          state_next   = (bit_idx == 3'd7) ? BK_PAD0 : BK_BITS;
        end else begin
          sub_next   = sub + 2'd1;
          state_next = BK_BITS;
        end
      end
    end
  end

  assign pop = load && res.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_LEAD;
      bit_idx  <= '0;
      sub      <= '0;
      tmo_done <= 1'b0;
    end else begin
      state    <= state_next;
      bit_idx  <= bit_idx_next;
      sub      <= sub_next;
      tmo_done <= tmo_done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data <= res;
  end

endmodule

/* rtl/two_wire_debug_link.sv */
// top level of the two-wire debug link
//
// in_valid/in_ready/in_data carry one poll per transaction: sampled clock and
// data line levels plus an optional host character. out_valid/out_ready/
// out_data carry result transactions, either a port write or a received
// character, with last set on the final result of a poll. cfg_wr_en with
// cfg_wr_data loads the 16-bit send timeout in polls.
// a poll that yields results passes through the command queue before the
// output register shows its first result. polls are taken one per cycle
// while the queue is not full; a poll that yields nothing produces no output
// transaction. a turnaround send expands to 26 results; the sequencer's
// single output register gives one result per cycle while out_ready is high.
// between the poll decoder and the sequencer sits a command queue of
// QUEUE_DEPTH entries; in_ready drops only while it is full, which happens
// when the receiver stalls or a send burst is draining.
// a stalled receiver holds the output register; nothing is lost or dropped.
// reset returns the link to waiting for a start, clears the queue and the
// output valid, and restores the timeout to 1000 polls.
module two_wire_debug_link import twdl_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  poll_t       in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_data,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic accept, push, pop, empty, full;
  cmd_t cmd, head;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  twdl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .accept     (accept),
    .poll       (in_data),
    .push       (push),
    .cmd        (cmd)
  );

  twdl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  twdl_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

/* rtl/twdl_checker.sv */
// port-level checks for the two-wire debug link, bound to the top level
module twdl_checker import twdl_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    out_valid,
  input logic    out_ready,
  input result_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.is_port_write != out_data.is_rx_byte))
    else $error("result must be exactly one kind");

  a_rx_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_rx_byte |-> out_data.port_value == 4'h0 && out_data.last)
    else $error("received byte result malformed");

  a_port_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_port_write |-> out_data.rx_byte == 7'h00)
    else $error("port write carries byte data");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind two_wire_debug_link twdl_checker u_twdl_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

/* dv/two_wire_debug_link_tb.sv */
// self-checking testbench for the two-wire debug link: directed table, random polls, predictor
`timescale 1ns / 100ps

module two_wire_debug_link_tb;
  import twdl_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam int PRINT_CAP    = 30;

  typedef struct packed {
    poll_t   poll;
    logic    table_checked;
    logic    has_result;
    result_t res;
  } stim_row_t;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  poll_t       in_data     = '0;
  logic        out_valid;
  logic        out_ready   = 1'b1;
  result_t     out_data;
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  int cycle_count = 0;
  int err_count   = 0;
  int n_polls     = 0;
  int n_checked   = 0;
  int n_rx        = 0;
  int n_bursts    = 0;
  int n_abandoned = 0;
  bit gaps_on     = 1'b1;
  bit stalls_on   = 1'b1;

  result_t   link_results_due[$];
  result_t   poll_out[$];
  stim_row_t stim_table[$];

  // predictor state
  phase_t      m_phase;
  logic        m_prev_clk;
  logic        m_prev_dat;
  logic [3:0]  m_bits;
  logic [7:0]  m_byte;
  logic [7:0]  m_pending;
  logic        m_armed;
  logic [15:0] m_ticks;
  logic [15:0] m_timeout;

  two_wire_debug_link u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (err_count < PRINT_CAP)
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    err_count++;
  endtask

  function automatic void push_port(input logic [3:0] v);
    poll_out.push_back({1'b1, v, 1'b0, 7'd0, 1'b0});
  endfunction

  task automatic link_predict(input poll_t p);
    logic       pc;
    logic       pd;
    logic [3:0] d;
    result_t    r;
    pc = m_prev_clk;
    pd = m_prev_dat;
    poll_out.delete();
    m_prev_clk = p.clock_line;
    m_prev_dat = p.data_line;
    if (m_armed) begin
      if (m_ticks >= m_timeout) begin
        push_port(PORT_IDLE);
        m_phase = PH_WAIT_START;
        m_ticks = '0;
        m_armed = 1'b0;
        n_abandoned++;
      end else begin
        m_ticks = m_ticks + 16'd1;
      end
    end
    if (p.host_char_valid) begin
      m_pending = p.host_char;
      m_phase   = PH_WAIT_SEND;
      m_ticks   = '0;
      m_armed   = 1'b1;
    end
    case (m_phase)
      PH_WAIT_START: begin
        if (pc && pd && p.clock_line && !p.data_line) begin
          // start in mid-byte aborts the byte
          if (m_bits > 4'd0 && m_bits < BITS_PER_CHAR) begin
            m_armed = 1'b0;
            m_ticks = '0;
            m_bits  = BITS_PER_CHAR;
          end else begin
            m_phase = PH_START;
          end
        end
      end
      PH_START: begin
        m_bits = '0;
        m_byte = '0;
        if (!p.clock_line) m_phase = PH_LOW;
      end
      PH_LOW: m_phase = PH_HI_FIRST;
      PH_HI_FIRST: begin
        if (p.clock_line) begin
          if (m_bits < 4'd8) m_byte = m_byte | ({7'd0, p.data_line} << m_bits);
          m_bits  = m_bits + 4'd1;
          m_phase = PH_HI_NEXT;
          if (m_bits == BITS_PER_CHAR) begin
            if (m_byte == TURN_BYTE) begin
              push_port(READY_STROBE);
              m_phase = PH_SEND;
            end else begin
              if (m_byte < TURN_BYTE) begin
                poll_out.push_back({1'b0, 4'd0, 1'b1, m_byte[6:0], 1'b0});
                n_rx++;
              end
              m_byte = '0;
            end
          end
        end
      end
      PH_HI_NEXT: begin
        if (!p.clock_line) m_phase = (m_bits == BITS_PER_CHAR) ? PH_WAIT_START : PH_LOW;
      end
      PH_WAIT_SEND: begin
        push_port(READY_STROBE);
        m_phase = PH_WAIT_START;
      end
      PH_SEND: begin
        m_armed = 1'b0;
        m_ticks = '0;
        for (int i = 0; i < 8; i++) begin
          d = {m_pending[i], 3'b000};
          push_port(d);
          push_port(d | READY_STROBE);
          push_port(d);
        end
        push_port(PORT_IDLE);
        push_port(PORT_IDLE);
        m_phase = PH_WAIT_START;
        n_bursts++;
      end
      default: ;
    endcase
    if (poll_out.size() > 0) begin
      r = poll_out.pop_back();
      r.last = 1'b1;
      poll_out.push_back(r);
    end
  endtask

  task automatic drive_poll(input poll_t p);
    int gap;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    link_predict(p);
    n_polls++;
  endtask

  task automatic queue_predicted();
    foreach (poll_out[i]) link_results_due.push_back(poll_out[i]);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (link_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    m_timeout = v;
  endtask

  function automatic poll_t make_poll(input logic c, input logic d);
    poll_t p;
    p.clock_line      = c;
    p.data_line       = d;
    p.host_char_valid = 1'b0;
    p.host_char       = 8'($urandom);
    return p;
  endfunction

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return TURN_BYTE;
      3:       return {1'b1, 7'($urandom)};
      4:       return 8'h7f;
      5:       return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  // well-formed frames with random content, plus truncated frames, host chars and noise
  task automatic run_traffic(input int n_target);
    poll_t      frame[$];
    int         sent;
    int         kind;
    int         limit;
    logic [7:0] ch;
    sent = 0;
    while (sent < n_target) begin
      frame.delete();
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        ch = pick_char();
        frame.push_back(make_poll(1'b1, 1'b1));
        if ($urandom_range(0, 2) == 0) begin
          frame[0].host_char_valid = 1'b1;
          frame[0].host_char       = 8'($urandom);
        end
        frame.push_back(make_poll(1'b1, 1'b0));
        frame.push_back(make_poll(1'b0, 1'($urandom)));
        frame.push_back(make_poll(1'b0, 1'($urandom)));
        for (int i = 0; i < 8; i++) begin
          frame.push_back(make_poll(1'b1, ch[i]));
          frame.push_back(make_poll(1'b0, 1'($urandom)));
          frame.push_back(make_poll(1'b0, 1'($urandom)));
        end
      end else if (kind < 82) begin
        frame.push_back(make_poll(1'($urandom), 1'($urandom)));
        frame[0].host_char_valid = 1'b1;
      end else begin
        repeat ($urandom_range(1, 6)) frame.push_back(make_poll(1'($urandom), 1'($urandom)));
      end
      limit = frame.size();
      if (kind >= 55 && kind < 65) limit = $urandom_range(1, frame.size() - 1);
      for (int i = 0; i < limit; i++) begin
        if ($urandom_range(0, 39) == 0) begin
          frame[i].host_char_valid = 1'b1;
          frame[i].host_char       = 8'($urandom);
        end
        drive_poll(frame[i]);
        queue_predicted();
        sent++;
      end
    end
  endtask

  function automatic void add_row(input logic c, input logic d, input logic hv,
                                  input logic [7:0] hc, input logic tabled,
                                  input logic has_res, input result_t res);
    stim_row_t row;
    row.poll.clock_line      = c;
    row.poll.data_line       = d;
    row.poll.host_char_valid = hv;
    row.poll.host_char       = hc;
    row.table_checked        = tabled;
    row.has_result           = has_res;
    row.res                  = res;
    stim_table.push_back(row);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("two_wire_debug_link_tb: errors");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (stalls_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      n_checked++;
      if (link_results_due.size() == 0) begin
        report_mismatch("result with nothing expected", 16'(out_data), 16'd0);
      end else begin
        want = link_results_due.pop_front();
        if (out_data.is_port_write !== want.is_port_write)
          report_mismatch("is_port_write", 16'(out_data.is_port_write), 16'(want.is_port_write));
        if (out_data.port_value !== want.port_value)
          report_mismatch("port_value", 16'(out_data.port_value), 16'(want.port_value));
        if (out_data.is_rx_byte !== want.is_rx_byte)
          report_mismatch("is_rx_byte", 16'(out_data.is_rx_byte), 16'(want.is_rx_byte));
        if (out_data.rx_byte !== want.rx_byte)
          report_mismatch("rx_byte", 16'(out_data.rx_byte), 16'(want.rx_byte));
        if (out_data.last !== want.last)
          report_mismatch("last", 16'(out_data.last), 16'(want.last));
      end
    end
  end

  initial begin
    result_t    strobe_last;
    logic [15:0] mid_timeout;
    strobe_last = {1'b1, READY_STROBE, 1'b0, 7'd0, 1'b1};

    m_phase    = PH_WAIT_START;
    m_prev_clk = 1'b0;
    m_prev_dat = 1'b0;
    m_bits     = BITS_PER_CHAR;
    m_byte     = '0;
    m_pending  = '0;
    m_armed    = 1'b0;
    m_ticks    = '0;
    m_timeout  = TIMEOUT_RESET;

    // idle poll, host char 0xff with lines high, then a turnaround byte
    add_row(1'b0, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0, '0);
    add_row(1'b1, 1'b1, 1'b1, 8'hff, 1'b1, 1'b1, strobe_last);
    add_row(1'b1, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0, '0);
    add_row(1'b0, 1'b0, 1'b0, 8'hff, 1'b0, 1'b0, '0);
    add_row(1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, '0);
    for (int i = 0; i < 7; i++) begin
      add_row(1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, '0);
      add_row(1'b0, 1'b1, 1'b0, 8'hff, 1'b0, 1'b0, '0);
      add_row(1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, '0);
    end
    add_row(1'b1, 1'b1, 1'b0, 8'h00, 1'b1, 1'b1, strobe_last);
    add_row(1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, '0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) begin
      drive_poll(stim_table[i].poll);
      if (!stim_table[i].table_checked) begin
        queue_predicted();
      end else begin
        if (poll_out.size() != 32'(stim_table[i].has_result) ||
            (stim_table[i].has_result && poll_out[0] != stim_table[i].res))
          report_mismatch("table row vs predictor", 16'(i), 16'(poll_out.size()));
        if (stim_table[i].has_result) link_results_due.push_back(stim_table[i].res);
      end
    end

    run_traffic(80);
    write_timeout(16'd1);
    run_traffic(90);
    write_timeout(16'hffff);
    run_traffic(90);
    mid_timeout = 16'($urandom_range(2, 60));
    write_timeout(mid_timeout);
    run_traffic(60);

    // closing stretch with both sides always ready
    write_timeout(TIMEOUT_RESET);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    run_traffic(40);
    settle();

    $display("covered %0d polls, %0d results checked: %0d chars received, %0d send bursts,",
             n_polls, n_checked, n_rx, n_bursts);
    $display("%0d abandoned sends, timeouts 1000/1/65535/%0d", n_abandoned, mid_timeout);
    if (err_count == 0 && link_results_due.size() == 0) begin
      $display("two_wire_debug_link_tb: clean");
    end else begin
      $display("two_wire_debug_link_tb: errors");
    end
    $finish;
  end

endmodule

/* two_wire_debug_link.f */
rtl/twdl_pkg.sv
rtl/twdl_front.sv
rtl/twdl_queue.sv
rtl/twdl_back.sv
rtl/two_wire_debug_link.sv
rtl/twdl_checker.sv
dv/two_wire_debug_link_tb.sv
